### sv/bucketed_hash_table_defines.svh
// Assertion macros for the bucketed hash table checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BUCKETED_HASH_TABLE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_DEFINES_SVH

// Checked on every edge outside reset.
`define BHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/bht_pkg.sv
// Types and constants for the bucketed hash table.
// No dependencies; used by the top level, the remainder unit and the checker.
package bht_pkg;

    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int BKT_OUT_W = 4;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REPLACED  = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CMP,
        ST_WR
    } t_state;

endpackage

### sv/bht_mod.sv
// Remainder unit: key modulo BUCKETS by reciprocal multiplication; key, quotient and remainder are registered in turn.
// Depends on bht_pkg.
module bht_mod
    import bht_pkg::*;
#(
    parameter int BUCKETS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] o_rem
);

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int LW    = $clog2(BUCKETS);
    localparam int SHIFT = KEY_W + LW;
    localparam int RW    = KEY_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

    logic                  r_stg1;
    logic                  r_stg2;
    logic                  r_done;
    logic [KEY_W-1:0]      r_key;
    logic [KEY_W-1:0]      r_quo;
    logic [BW-1:0]         r_rem;
    logic [KEY_W+RW-1:0]   prod;
    logic [KEY_W-1:0]      quo;
    logic [KEY_W-1:0]      back;
    logic [KEY_W-1:0]      diff;

    // quotient = (key * ceil(2^SHIFT / BUCKETS)) >> SHIFT, exact for 31-bit keys
    assign prod = {{RW{1'b0}}, r_key} * {{KEY_W{1'b0}}, RW'(RECIP)};
    assign quo  = KEY_W'(prod >> SHIFT);
    assign back = r_quo * KEY_W'(BUCKETS);
    assign diff = r_key - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg1 <= 1'b0;
            r_stg2 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_stg1 <= i_start;
            r_stg2 <= r_stg1;
            r_done <= r_stg2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_stg1) begin
            r_quo <= quo;
        end
        if (r_stg2) begin
            r_rem <= BW'(diff);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/bucketed_hash_table.sv
// Bucketed key/value table, top level.
// Depends on bht_pkg and bht_mod.
//
// Request channel: i_valid with i_kind, i_key, i_value; the block drives o_stall.
// A request is taken when i_valid is high and o_stall is low. o_stall is high
// while a request is in progress.
// Result channel: o_valid with o_status, o_table_empty, o_bucket; the receiver
// drives i_stall. A result is held unchanged until taken.
// Sequence: the bucket comes from the reciprocal-multiply remainder unit and
// is handed to the sequencer, then each slot of the bucket costs a key memory
// read and a compare, then the row is updated. The next request is taken the
// cycle after.
// One request is handled at a time: a new one is taken only after the current
// one has updated its row.
// A finished result waits in the output register while the next request runs;
// if it is still not taken when the next one finishes, the update waits.
// Reset clears all slot valid marks, the entry count and the output valid.
module bucketed_hash_table
    import bht_pkg::*;
#(
    parameter int BUCKETS          = 10,
    parameter int SLOTS_PER_BUCKET = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [VAL_W-1:0]     i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic                 o_table_empty,
    output logic [BKT_OUT_W-1:0] o_bucket
);

    localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CW    = $clog2(TOTAL + 1);

    t_state r_state, n_state;

    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IW-1:0]    r_idx;
    logic [SW-1:0]    r_slot;
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;
    logic             r_free;
    logic [IW-1:0]    r_free_idx;
    logic [TOTAL-1:0] r_valid;
    logic [CW-1:0]    r_count;
    logic [KEY_W-1:0] r_rd_key;
    logic [BKT_OUT_W-1:0] r_bucket;

    logic [KEY_W-1:0] r_key_mem [TOTAL];
    logic [VAL_W-1:0] r_val_mem [TOTAL];

    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_empty;
    logic [BKT_OUT_W-1:0] r_out_bucket;

    logic          mod_done;
    logic [BW-1:0] mod_rem;
    logic [IW-1:0] base_idx;
    logic [BW+BKT_OUT_W-1:0] bkt_ext;

    logic    in_acc;
    logic    c_start;
    logic    c_init;
    logic    c_rd;
    logic    c_cmp;
    logic    c_wr;
    logic    slot_last;

    t_status       wr_status;
    logic [IW-1:0] wr_idx;
    logic          we_key;
    logic          we_val;
    logic          set_v;
    logic          clr_v;
    logic [CW-1:0] n_count;

    bht_mod #(
        .BUCKETS (BUCKETS)
    ) u_bht_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_key   (i_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign in_acc    = i_valid && !o_stall;
    assign slot_last = (r_slot == SW'(SLOTS_PER_BUCKET - 1));
    assign base_idx  = IW'(IW'(mod_rem) * IW'(SLOTS_PER_BUCKET));
    assign bkt_ext   = {{BKT_OUT_W{1'b0}}, mod_rem};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc)   n_state = ST_MOD;
            ST_MOD:  if (mod_done) n_state = ST_RD;
            ST_RD:   n_state = ST_CMP;
            ST_CMP:  n_state = slot_last ? ST_WR : ST_RD;
            ST_WR:   if (!(r_out_valid && i_stall)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        c_start = 1'b0;
        c_init  = 1'b0;
        c_rd    = 1'b0;
        c_cmp   = 1'b0;
        c_wr    = 1'b0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                c_start = i_valid;
            end
            ST_MOD:  c_init = mod_done;
            ST_RD:   c_rd   = 1'b1;
            ST_CMP:  c_cmp  = 1'b1;
            ST_WR:   c_wr   = !(r_out_valid && i_stall);
            default: ;
        endcase
    end

    // Row update decision
    always_comb begin
        wr_status = STAT_NOT_FOUND;
        wr_idx    = r_hit_idx;
        we_key    = 1'b0;
        we_val    = 1'b0;
        set_v     = 1'b0;
        clr_v     = 1'b0;
        n_count   = r_count;
        if (r_kind == KIND_INSERT) begin
            if (r_hit) begin
                wr_status = STAT_REPLACED;
                we_val    = c_wr;
            end else if (r_free) begin
                wr_status = STAT_INSERTED;
                wr_idx    = r_free_idx;
                we_key    = c_wr;
                we_val    = c_wr;
                set_v     = c_wr;
                n_count   = r_count + 1'b1;
            end else begin
                wr_status = STAT_FULL;
            end
        end else begin
            if (r_hit) begin
                wr_status = STAT_REMOVED;
                clr_v     = c_wr;
                n_count   = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (c_wr) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                if (set_v) r_valid[wr_idx] <= 1'b1;
                if (clr_v) r_valid[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_start) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (c_init) begin
            r_idx    <= base_idx;
            r_slot   <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_bucket <= bkt_ext[BKT_OUT_W-1:0];
        end
        if (c_cmp) begin
            if (r_valid[r_idx]) begin
                if (!r_hit && r_rd_key == r_key) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                end
            end else if (!r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (!slot_last) begin
                r_idx  <= r_idx + 1'b1;
                r_slot <= r_slot + 1'b1;
            end
        end
        if (c_wr) begin
            r_out_status <= wr_status;
            r_out_empty  <= (n_count == '0);
            r_out_bucket <= r_bucket;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rd) begin
            r_rd_key <= r_key_mem[r_idx];
        end
        if (we_key) begin
            r_key_mem[wr_idx] <= r_key;
        end
        if (we_val) begin
            r_val_mem[wr_idx] <= r_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_table_empty = r_out_empty;
    assign o_bucket      = r_out_bucket;

endmodule

### sv/bht_chk.sv
// Port-level checker for the bucketed hash table, bound to the top level.
// Depends on bht_pkg and bucketed_hash_table_defines.svh.
`include "bucketed_hash_table_defines.svh"

module bht_chk
    import bht_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic [2:0]           o_status,
    input logic                 o_table_empty,
    input logic [BKT_OUT_W-1:0] o_bucket
);

    `BHT_ASSERT(a_status_code, o_valid |-> (o_status <= STAT_FULL), "bad status code")
    `BHT_ASSERT(a_busy_after_req, (i_valid && !o_stall) |=> o_stall, "request not held off")
    `BHT_ASSERT(a_result_frees_input, $rose(o_valid) |-> $fell(o_stall), "result without release")
    `BHT_ASSERT(a_insert_not_empty, (o_valid && o_status == STAT_INSERTED) |-> !o_table_empty, "empty after insert")

endmodule

bind bucketed_hash_table bht_chk u_bht_chk (.*);
